FILE: src/drst_pkg.sv
package drst_pkg;

    localparam int NUM_SLOTS_DEF = 8;

    localparam int ADDR_W   = 32;
    localparam int UNIV_W   = 16;
    localparam int DELAY_W  = 10;
    localparam int IDX_W    = 3;
    localparam int KIND_W   = 2;
    localparam int TICK_W   = 64;
    localparam int STAT_PH_W = 4;
    localparam int DISC_PH_W = 14;
    localparam int PERF_PH_W = 13;

    localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM   = 2'd2;

    localparam logic MODE_SCHED = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACK,
        ST_SCAN,
        ST_SUM
    } t_state;

    typedef struct packed {
        logic               sched;
        logic               tick;
        logic               shift;
        logic [ADDR_W-1:0]  addr;
        logic [UNIV_W-1:0]  univ;
        logic [DELAY_W-1:0] delay;
    } t_cell_cmd;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
    } t_find;

    typedef struct packed {
        logic              pend;
        logic [ADDR_W-1:0] addr;
        logic [UNIV_W-1:0] univ;
        logic [IDX_W-1:0]  idx;
    } t_emit;

endpackage

FILE: src/delayed_reply_slot_timer.sv
// Delayed-reply slot timer with NUM_SLOTS slots held in a row of cells.
// Input channel: i_valid with o_stall; a beat carries i_mode, i_source_addr,
// i_universe and i_delay_ticks. Output channel: o_valid with i_stall; a beat
// carries one result, and o_last marks the final result of an input beat.
// A schedule beat (mode 0) writes the lowest free slot in the cycle it is
// accepted and yields one acknowledgement beat, which is registered from the
// ACK state. A tick beat (mode 1) counts every busy slot down and copies the
// expiring slots into the emission chain, which then shifts one cell per
// cycle toward slot 0 unless a stalled output holds an expired slot there;
// the summary beat follows the last shift. Reply beats leave in slot order.
// One input beat is in work at a time; o_stall is high from acceptance until
// the last result has been moved into the output register.
// When the receiver stalls, the output register holds its beat and the chain
// waits at the next expired slot.
// Synchronous reset frees all slots, clears the tick count, sets the status
// phase to 0 and the discovery and performance phases to 1.
module delayed_reply_slot_timer #(
    parameter int NUM_SLOTS = drst_pkg::NUM_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_mode,
    input  logic [drst_pkg::ADDR_W-1:0]   i_source_addr,
    input  logic [drst_pkg::UNIV_W-1:0]   i_universe,
    input  logic [drst_pkg::DELAY_W-1:0]  i_delay_ticks,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [drst_pkg::KIND_W-1:0]   o_kind,
    output logic                          o_accepted,
    output logic [drst_pkg::ADDR_W-1:0]   o_reply_addr,
    output logic [drst_pkg::UNIV_W-1:0]   o_reply_universe,
    output logic [drst_pkg::IDX_W-1:0]    o_slot_index,
    output logic                          o_status_due,
    output logic                          o_discovery_due,
    output logic                          o_perf_due,
    output logic [drst_pkg::TICK_W-1:0]   o_tick_count,
    output logic                          o_last
);
    import drst_pkg::*;

    localparam int CNT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_ack_acc;
    logic [IDX_W-1:0]    r_ack_idx;
    logic [STAT_PH_W-1:0] r_stat_ph;
    logic [DISC_PH_W-1:0] r_disc_ph;
    logic [PERF_PH_W-1:0] r_perf_ph;
    logic [TICK_W-1:0]   r_elapsed;
    logic                r_flag_stat, r_flag_disc, r_flag_perf;

    logic                r_ovalid, n_ovalid;
    logic [KIND_W-1:0]   r_kind, n_kind;
    logic                r_acc, n_acc;
    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [UNIV_W-1:0]   r_univ, n_univ;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic                r_stat, n_stat;
    logic                r_disc, n_disc;
    logic                r_perf, n_perf;
    logic [TICK_W-1:0]   r_ticks, n_ticks;
    logic                r_last, n_last;

    logic                w_in_acc;
    logic                w_load;
    logic                w_step;
    logic                w_cnt_end;
    t_cell_cmd           w_cmd;
    t_find               w_find [NUM_SLOTS+1];
    t_emit               w_emit [NUM_SLOTS+1];

    assign w_in_acc  = i_valid && !o_stall;
    assign w_load    = !r_ovalid || !i_stall;
    assign w_step    = (r_state == ST_SCAN) && (!w_emit[0].pend || w_load);
    assign w_cnt_end = (r_cnt == CNT_W'(NUM_SLOTS - 1));

    assign w_find[0] = '0;
    assign w_emit[NUM_SLOTS] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
        drst_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_index (IDX_W'(g)),
            .i_find  (w_find[g]),
            .o_find  (w_find[g+1]),
            .i_emit  (w_emit[g+1]),
            .o_emit  (w_emit[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_mode == MODE_TICK) ? ST_SCAN : ST_ACK;
                end
            end
            ST_ACK: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (w_step && w_cnt_end) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        w_cmd.sched = w_in_acc && (i_mode == MODE_SCHED);
        w_cmd.tick  = w_in_acc && (i_mode == MODE_TICK);
        w_cmd.shift = w_step;
        w_cmd.addr  = i_source_addr;
        w_cmd.univ  = i_universe;
        w_cmd.delay = (i_delay_ticks == '0) ? DELAY_W'(1) : i_delay_ticks;

        n_cnt = r_cnt;
        if (r_state == ST_IDLE) begin
            n_cnt = '0;
        end else if (w_step) begin
            n_cnt = r_cnt + CNT_W'(1);
        end

        n_ovalid = r_ovalid;
        n_kind   = r_kind;
        n_acc    = r_acc;
        n_addr   = r_addr;
        n_univ   = r_univ;
        n_idx    = r_idx;
        n_stat   = r_stat;
        n_disc   = r_disc;
        n_perf   = r_perf;
        n_ticks  = r_ticks;
        n_last   = r_last;
        if (w_load) begin
            n_ovalid = 1'b0;
            n_acc    = 1'b0;
            n_addr   = '0;
            n_univ   = '0;
            n_idx    = '0;
            n_stat   = 1'b0;
            n_disc   = 1'b0;
            n_perf   = 1'b0;
            n_ticks  = '0;
            n_last   = 1'b0;
            case (r_state)
                ST_ACK: begin
                    n_ovalid = 1'b1;
                    n_kind   = KIND_ACK;
                    n_acc    = r_ack_acc;
                    n_idx    = r_ack_idx;
                    n_last   = 1'b1;
                end
                ST_SCAN: begin
                    n_ovalid = w_emit[0].pend;
                    n_kind   = KIND_REPLY;
                    n_addr   = w_emit[0].addr;
                    n_univ   = w_emit[0].univ;
                    n_idx    = w_emit[0].idx;
                end
                ST_SUM: begin
                    n_ovalid = 1'b1;
                    n_kind   = KIND_SUM;
                    n_stat   = r_flag_stat;
                    n_disc   = r_flag_disc;
                    n_perf   = r_flag_perf;
                    n_ticks  = r_elapsed;
                    n_last   = 1'b1;
                end
                default: n_ovalid = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_ovalid  <= 1'b0;
            r_stat_ph <= '0;
            r_disc_ph <= DISC_PH_W'(1);
            r_perf_ph <= PERF_PH_W'(1);
            r_elapsed <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (w_cmd.tick) begin
                r_stat_ph <= r_stat_ph + STAT_PH_W'(1);
                r_disc_ph <= r_disc_ph + DISC_PH_W'(1);
                r_perf_ph <= r_perf_ph + PERF_PH_W'(1);
                r_elapsed <= r_elapsed + TICK_W'(1);
            end
        end
        if (w_cmd.sched) begin
            r_ack_acc <= w_find[NUM_SLOTS].hit;
            r_ack_idx <= w_find[NUM_SLOTS].hit ? w_find[NUM_SLOTS].idx : '0;
        end
        if (w_cmd.tick) begin
            r_flag_stat <= (r_stat_ph == '0);
            r_flag_disc <= (r_disc_ph == '0);
            r_flag_perf <= (r_perf_ph == '0);
        end
        r_kind  <= n_kind;
        r_acc   <= n_acc;
        r_addr  <= n_addr;
        r_univ  <= n_univ;
        r_idx   <= n_idx;
        r_stat  <= n_stat;
        r_disc  <= n_disc;
        r_perf  <= n_perf;
        r_ticks <= n_ticks;
        r_last  <= n_last;
    end

    assign o_valid          = r_ovalid;
    assign o_kind           = r_kind;
    assign o_accepted       = r_acc;
    assign o_reply_addr     = r_addr;
    assign o_reply_universe = r_univ;
    assign o_slot_index     = r_idx;
    assign o_status_due     = r_stat;
    assign o_discovery_due  = r_disc;
    assign o_perf_due       = r_perf;
    assign o_tick_count     = r_ticks;
    assign o_last           = r_last;

    a_drop_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_ACK) && !o_accepted |-> (o_slot_index == '0))
        else $error("dropped schedule reports a nonzero slot");

    a_reply_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_REPLY) |-> !o_last && !o_accepted && (o_tick_count == '0))
        else $error("reply beat carries summary or acknowledgement fields");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (32'(r_cnt) <= NUM_SLOTS - 1))
        else $error("emission chain counter ran past the last cell");

    a_sum_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) && !$past(r_state == ST_SUM) |-> $past(r_state == ST_SCAN))
        else $error("summary state entered without a chain pass");

endmodule

FILE: src/drst_cell.sv
module drst_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  drst_pkg::t_cell_cmd          i_cmd,
    input  logic [drst_pkg::IDX_W-1:0]   i_index,
    input  drst_pkg::t_find              i_find,
    output drst_pkg::t_find              o_find,
    input  drst_pkg::t_emit              i_emit,
    output drst_pkg::t_emit              o_emit
);
    import drst_pkg::*;

    logic [DELAY_W-1:0] r_delay, n_delay;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [UNIV_W-1:0]  r_univ, n_univ;
    t_emit              r_emit, n_emit;
    logic               w_free;
    logic               w_take;

    assign w_free = (r_delay == '0);
    assign w_take = i_cmd.sched && !i_find.hit && w_free;

    always_comb begin
        if (i_find.hit || !w_free) begin
            o_find = i_find;
        end else begin
            o_find.hit = 1'b1;
            o_find.idx = i_index;
        end
    end

    always_comb begin
        n_delay = r_delay;
        n_addr  = r_addr;
        n_univ  = r_univ;
        if (w_take) begin
            n_delay = i_cmd.delay;
            n_addr  = i_cmd.addr;
            n_univ  = i_cmd.univ;
        end else if (i_cmd.tick && !w_free) begin
            n_delay = r_delay - DELAY_W'(1);
        end
    end

    always_comb begin
        n_emit = r_emit;
        if (i_cmd.tick) begin
            n_emit.pend = (r_delay == DELAY_W'(1));
            n_emit.addr = r_addr;
            n_emit.univ = r_univ;
            n_emit.idx  = i_index;
        end else if (i_cmd.shift) begin
            n_emit = i_emit;
        end
    end

    assign o_emit = r_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay     <= '0;
            r_emit.pend <= 1'b0;
        end else begin
            r_delay <= n_delay;
            r_emit  <= n_emit;
        end
        r_addr <= n_addr;
        r_univ <= n_univ;
    end

endmodule

FILE: sim/delayed_reply_slot_timer_tb.sv
`timescale 1ns / 1ps

import drst_pkg::*;

typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              accepted;
    logic [ADDR_W-1:0] addr;
    logic [UNIV_W-1:0] univ;
    logic [IDX_W-1:0]  slot;
    logic              status;
    logic              discovery;
    logic              perf;
    logic [TICK_W-1:0] ticks;
    logic              last;
} t_timer_result;

class slot_timer_scoreboard;
    logic [DELAY_W-1:0]   slot_delay [NUM_SLOTS_DEF];
    logic [ADDR_W-1:0]    slot_addr [NUM_SLOTS_DEF];
    logic [UNIV_W-1:0]    slot_univ [NUM_SLOTS_DEF];
    logic [STAT_PH_W-1:0] status_phase;
    logic [DISC_PH_W-1:0] discovery_phase;
    logic [PERF_PH_W-1:0] perf_phase;
    logic [TICK_W-1:0]    elapsed;
    t_timer_result        due_q [$];
    int                   errors;

    function new();
        for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
            slot_delay[i] = '0;
            slot_addr[i]  = '0;
            slot_univ[i]  = '0;
        end
        status_phase    = '0;
        discovery_phase = DISC_PH_W'(1);
        perf_phase      = PERF_PH_W'(1);
        elapsed         = '0;
        errors          = 0;
    endfunction

    function int pending();
        return due_q.size();
    endfunction

    // Works out the result beats caused by one accepted input beat.
    function void note_beat(logic mode, logic [ADDR_W-1:0] addr, logic [UNIV_W-1:0] univ,
                            logic [DELAY_W-1:0] delay);
        t_timer_result r;
        logic          st;
        logic          dc;
        logic          pf;
        bit            hit;
        if (mode == MODE_SCHED) begin
            r = '0;
            r.kind = KIND_ACK;
            r.last = 1'b1;
            hit = 0;
            for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                if (!hit && slot_delay[i] == '0) begin
                    slot_addr[i]  = addr;
                    slot_univ[i]  = univ;
                    slot_delay[i] = (delay == '0) ? DELAY_W'(1) : delay;
                    r.accepted    = 1'b1;
                    r.slot        = IDX_W'(i);
                    hit = 1;
                end
            end
            due_q.push_back(r);
        end else begin
            st = (status_phase == '0);
            dc = (discovery_phase == '0);
            pf = (perf_phase == '0);
            perf_phase      = perf_phase + PERF_PH_W'(1);
            discovery_phase = discovery_phase + DISC_PH_W'(1);
            for (int i = 0; i < NUM_SLOTS_DEF; i++) begin
                if (slot_delay[i] != '0) begin
                    slot_delay[i] = slot_delay[i] - DELAY_W'(1);
                    if (slot_delay[i] == '0) begin
                        r = '0;
                        r.kind = KIND_REPLY;
                        r.addr = slot_addr[i];
                        r.univ = slot_univ[i];
                        r.slot = IDX_W'(i);
                        slot_addr[i] = '0;
                        slot_univ[i] = '0;
                        due_q.push_back(r);
                    end
                end
            end
            status_phase = status_phase + STAT_PH_W'(1);
            elapsed      = elapsed + TICK_W'(1);
            r = '0;
            r.kind      = KIND_SUM;
            r.status    = st;
            r.discovery = dc;
            r.perf      = pf;
            r.ticks     = elapsed;
            r.last      = 1'b1;
            due_q.push_back(r);
        end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function void check_result(t_timer_result got);
        t_timer_result want;
        if (due_q.size() == 0) begin
            $error("result beat of kind %0d arrived with nothing expected", got.kind);
            errors++;
            return;
        end
        want = due_q.pop_front();
        compare_field("kind", 64'(want.kind), 64'(got.kind));
        compare_field("accepted", 64'(want.accepted), 64'(got.accepted));
        compare_field("reply_addr", 64'(want.addr), 64'(got.addr));
        compare_field("reply_universe", 64'(want.univ), 64'(got.univ));
        compare_field("slot_index", 64'(want.slot), 64'(got.slot));
        compare_field("status_due", 64'(want.status), 64'(got.status));
        compare_field("discovery_due", 64'(want.discovery), 64'(got.discovery));
        compare_field("perf_due", 64'(want.perf), 64'(got.perf));
        compare_field("tick_count", want.ticks, got.ticks);
        compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
endclass

module delayed_reply_slot_timer_tb;
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic                i_mode = MODE_TICK;
    logic [ADDR_W-1:0]   i_source_addr = '0;
    logic [UNIV_W-1:0]   i_universe = '0;
    logic [DELAY_W-1:0]  i_delay_ticks = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic [KIND_W-1:0]   o_kind;
    logic                o_accepted;
    logic [ADDR_W-1:0]   o_reply_addr;
    logic [UNIV_W-1:0]   o_reply_universe;
    logic [IDX_W-1:0]    o_slot_index;
    logic                o_status_due;
    logic                o_discovery_due;
    logic                o_perf_due;
    logic [TICK_W-1:0]   o_tick_count;
    logic                o_last;

    slot_timer_scoreboard sb = new();
    t_timer_result        seen_beat;
    bit                   tx_idle_en = 0;
    bit                   rx_stall_en = 0;
    int                   stall_left = 0;

    delayed_reply_slot_timer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_source_addr    (i_source_addr),
        .i_universe       (i_universe),
        .i_delay_ticks    (i_delay_ticks),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_accepted       (o_accepted),
        .o_reply_addr     (o_reply_addr),
        .o_reply_universe (o_reply_universe),
        .o_slot_index     (o_slot_index),
        .o_status_due     (o_status_due),
        .o_discovery_due  (o_discovery_due),
        .o_perf_due       (o_perf_due),
        .o_tick_count     (o_tick_count),
        .o_last           (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            seen_beat.kind      = o_kind;
            seen_beat.accepted  = o_accepted;
            seen_beat.addr      = o_reply_addr;
            seen_beat.univ      = o_reply_universe;
            seen_beat.slot      = o_slot_index;
            seen_beat.status    = o_status_due;
            seen_beat.discovery = o_discovery_due;
            seen_beat.perf      = o_perf_due;
            seen_beat.ticks     = o_tick_count;
            seen_beat.last      = o_last;
            sb.check_result(seen_beat);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                    : $urandom_range(0, 2);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    function automatic int pick_gap();
        int r;
        if (!tx_idle_en) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [DELAY_W-1:0] pick_delay();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 70) return DELAY_W'($urandom_range(1, 12));
        if (r < 85) return DELAY_W'($urandom_range(13, 64));
        return DELAY_W'($urandom_range(0, 1023));
    endfunction

    task automatic send_beat(input logic mode, input logic [ADDR_W-1:0] addr,
                             input logic [UNIV_W-1:0] univ, input logic [DELAY_W-1:0] delay,
                             input int gap);
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_source_addr <= addr;
        i_universe    <= univ;
        i_delay_ticks <= delay;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        sb.note_beat(mode, addr, univ, delay);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_tick(input int gap);
        send_beat(MODE_TICK, $urandom, UNIV_W'($urandom), DELAY_W'($urandom), gap);
    endtask

    task automatic send_schedule(input logic [ADDR_W-1:0] addr, input logic [UNIV_W-1:0] univ,
                                 input logic [DELAY_W-1:0] delay, input int gap);
        send_beat(MODE_SCHED, addr, univ, delay, gap);
    endtask

    task automatic send_random(input int tick_pct);
        if ($urandom_range(0, 99) < tick_pct) begin
            send_tick(pick_gap());
        end else begin
            send_schedule($urandom, UNIV_W'($urandom), pick_delay(), pick_gap());
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All eight slots fall due on one tick, after a ninth schedule is refused.
        rx_stall_en = 1;
        send_tick(0);
        send_schedule('0, '0, '0, 0);
        send_schedule('1, '1, DELAY_W'(1), 0);
        for (int k = 2; k < NUM_SLOTS_DEF; k++) begin
            send_schedule($urandom, UNIV_W'($urandom), DELAY_W'(1), 0);
        end
        send_schedule(32'hA5A5_5A5A, 16'h1234, DELAY_W'(1023), 0);
        send_tick(0);
        send_schedule(32'h8000_0001, 16'h8001, '1, 0);
        send_schedule(32'h5A5A_A5A5, 16'h5A5A, DELAY_W'(2), 0);
        send_schedule(32'h0000_FFFF, 16'hFF00, DELAY_W'(10'h200), 0);
        send_tick(0);
        send_tick(0);
        send_schedule(32'hFFFF_0000, 16'h00FF, DELAY_W'(3), 0);
        drain_results();
        send_tick(0);
        send_tick(0);
        send_tick(0);

        for (int blk = 0; blk < 9; blk++) begin
            tx_idle_en  = ($urandom_range(0, 3) != 0);
            rx_stall_en = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < 39; n++) begin
                send_random(55);
            end
            if ($urandom_range(0, 2) == 0) begin
                drain_results();
            end
        end

        drain_results();
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("delayed_reply_slot_timer_tb: done, clean");
        end else begin
            $display("delayed_reply_slot_timer_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("delayed_reply_slot_timer_tb: done, errors");
        $finish;
    end
endmodule

FILE: sim.f
src/drst_pkg.sv
src/drst_cell.sv
src/delayed_reply_slot_timer.sv
sim/delayed_reply_slot_timer_tb.sv
